FILE: rtl/sha1_message_digest_macros.svh
// Assertion macros used by the SHA-1 digest top level.
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sha1_pkg.sv
// Shared types and constants for the SHA-1 digest block.
`timescale 1ns / 1ps
package sha1_pkg;

  localparam int WORD_W   = 32;
  localparam int NUM_SCHED = 16;
  localparam int NUM_HASH = 5;
  localparam int COUNT_W  = 61;
  localparam int LEN_W    = 64;
  localparam int FILL_W   = 6;
  localparam int RND_W    = 7;

  localparam logic [RND_W-1:0]  ROUND_LAST = 7'd79;
  localparam logic [RND_W-1:0]  ROUND_P2   = 7'd20;
  localparam logic [RND_W-1:0]  ROUND_P3   = 7'd40;
  localparam logic [RND_W-1:0]  ROUND_P4   = 7'd60;
  localparam logic [FILL_W-1:0] FILL_LAST  = 6'd63;
  localparam logic [2:0]        IDX_LAST   = 3'd4;
  localparam logic [7:0]        PAD_MARK   = 8'h80;

  // Word 0 of the chain sits at index 4.
  localparam logic [NUM_HASH-1:0][WORD_W-1:0] H_INIT = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K_P1 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_P2 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_P3 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_P4 = 32'hCA62C1D6;

  typedef enum logic [1:0] {
    PUSH_MSG,
    PUSH_MARK,
    PUSH_ZERO,
    PUSH_LEN
  } push_sel_t;

  typedef struct packed {
    logic      push;       // shift one byte into the block
    push_sel_t push_sel;
    logic      cap_len;    // latch the message bit length
    logic      load_work;  // copy chain into working vars, clear round count
    logic      round;      // run one compression round
    logic      add_chain;  // fold working vars into the chain
    logic      finish;     // hand digest to output, restart chain
  } dp_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              round_last;
    logic              out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/sha1_ctrl.sv
// Sequencer for byte intake, padding, compression and digest hand-off.
`timescale 1ns / 1ps
module sha1_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               byte_valid,
  input  logic               msg_end,
  input  sha1_pkg::dp_stat_t stat,
  output logic               in_stall,
  output sha1_pkg::dp_cmd_t  cmd
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   pend, pend_next;       // message ended, padding still owed
  logic   fin, fin_next;         // block in flight is the last one
  logic   mark, mark_next;       // 0x80 already pushed
  logic   wrap, wrap_next;       // length goes in the following block

  logic accept;
  logic fill_hi;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign fill_hi  = (stat.fill[5:3] == 3'b111);

  always_comb begin
    state_next = state;
    pend_next  = pend;
    fin_next   = fin;
    mark_next  = mark;
    wrap_next  = wrap;
    cmd        = '0;
    cmd.push_sel = PUSH_MSG;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (byte_valid) begin
            cmd.push = 1'b1;
            if (stat.fill == FILL_LAST) begin
              cmd.load_work = 1'b1;
              pend_next     = msg_end;
              fin_next      = 1'b0;
              state_next    = S_ROUND;
            end else if (msg_end) begin
              state_next = S_PAD;
            end
          end else if (msg_end) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        if (!mark) begin
          cmd.push_sel = PUSH_MARK;
          cmd.cap_len  = 1'b1;
          mark_next    = 1'b1;
          wrap_next    = fill_hi;
          if (stat.fill == FILL_LAST) begin
            cmd.load_work = 1'b1;
            fin_next      = 1'b0;
            wrap_next     = 1'b0;
            state_next    = S_ROUND;
          end
        end else begin
          cmd.push_sel = (fill_hi && !wrap) ? PUSH_LEN : PUSH_ZERO;
          if (stat.fill == FILL_LAST) begin
            cmd.load_work = 1'b1;
            fin_next      = !wrap;
            wrap_next     = 1'b0;
            state_next    = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (stat.round_last) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        if (fin) begin
          state_next = S_DONE;
        end else if (pend) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          pend_next  = 1'b0;
          fin_next   = 1'b0;
          mark_next  = 1'b0;
          wrap_next  = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // Entering padding straight from intake marks the message as ended.
    if (state == S_IDLE && state_next == S_PAD) begin
      pend_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
      fin   <= 1'b0;
      mark  <= 1'b0;
      wrap  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      fin   <= fin_next;
      mark  <= mark_next;
      wrap  <= wrap_next;
    end
  end

endmodule

FILE: rtl/sha1_dpath.sv
// Block register, rolling schedule, round logic, chain and digest output.
`timescale 1ns / 1ps
module sha1_dpath (
  input  logic               clk,
  input  logic               rst,
  input  sha1_pkg::dp_cmd_t  cmd,
  input  logic [7:0]         msg_byte,
  input  logic               out_stall,
  output sha1_pkg::dp_stat_t stat,
  output logic               out_valid,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last_word
);
  import sha1_pkg::*;

  logic [NUM_SCHED-1:0][WORD_W-1:0] sched;    // index 15 holds W of this round
  logic [WORD_W-1:0]                a, b, c, d, e;
  logic [NUM_HASH-1:0][WORD_W-1:0]  h;
  logic [COUNT_W-1:0]               byte_count;
  logic [LEN_W-1:0]                 len_bits;
  logic [RND_W-1:0]                 rnd;
  logic [NUM_HASH-1:0][WORD_W-1:0]  out_words;
  logic [2:0]                       out_idx;
  logic                             out_busy;

  logic [7:0]        push_byte;
  logic [WORD_W-1:0] f, k, tmp, w_mix, w_new;
  logic              out_take;

  always_comb begin
    case (cmd.push_sel)
      PUSH_MSG:  push_byte = msg_byte;
      PUSH_MARK: push_byte = PAD_MARK;
      PUSH_LEN:  push_byte = len_bits[{~byte_count[2:0], 3'b000} +: 8];
      default:   push_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (rnd < ROUND_P2) begin
      f = (b & c) | (~b & d);
      k = K_P1;
    end else if (rnd < ROUND_P3) begin
      f = b ^ c ^ d;
      k = K_P2;
    end else if (rnd < ROUND_P4) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_P3;
    end else begin
      f = b ^ c ^ d;
      k = K_P4;
    end
    tmp   = {a[26:0], a[31:27]} + f + e + k + sched[15];
    w_mix = sched[2] ^ sched[7] ^ sched[13] ^ sched[15];
    w_new = {w_mix[30:0], w_mix[31]};
  end

  assign out_take = out_busy && !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      sched <= (NUM_SCHED * WORD_W)'({sched, push_byte});
    end else if (cmd.round) begin
      sched <= {sched[14:0], w_new};
    end
    if (cmd.cap_len) begin
      len_bits <= {byte_count, 3'b000};
    end
    if (cmd.load_work) begin
      a <= h[4];
      b <= h[3];
      c <= h[2];
      d <= h[1];
      e <= h[0];
    end else if (cmd.round) begin
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
    if (cmd.finish) begin
      out_words <= h;
    end else if (out_take) begin
      out_words <= {out_words[3:0], {WORD_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h          <= H_INIT;
      byte_count <= '0;
      rnd        <= '0;
      out_idx    <= '0;
      out_busy   <= 1'b0;
    end else begin
      if (cmd.finish) begin
        h          <= H_INIT;
        byte_count <= '0;
      end else begin
        if (cmd.add_chain) begin
          h[4] <= h[4] + a;
          h[3] <= h[3] + b;
          h[2] <= h[2] + c;
          h[1] <= h[1] + d;
          h[0] <= h[0] + e;
        end
        if (cmd.push) begin
          byte_count <= byte_count + 1'b1;
        end
      end
      if (cmd.load_work) begin
        rnd <= '0;
      end else if (cmd.round) begin
        rnd <= rnd + 1'b1;
      end
      if (cmd.finish) begin
        out_idx  <= '0;
        out_busy <= 1'b1;
      end else if (out_take) begin
        out_idx <= out_idx + 1'b1;
        if (out_idx == IDX_LAST) begin
          out_busy <= 1'b0;
        end
      end
    end
  end

  assign stat.fill       = byte_count[FILL_W-1:0];
  assign stat.round_last = (rnd == ROUND_LAST);
  assign stat.out_busy   = out_busy;

  assign out_valid   = out_busy;
  assign digest_word = out_words[4];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == IDX_LAST);

endmodule

FILE: rtl/sha1_message_digest.sv
// Top level of the byte-serial SHA-1 digest block.
`timescale 1ns / 1ps
// SHA-1 over a byte stream. Each accepted word carries at most one message byte
// (byte_valid) and may close the message (msg_end); a word with neither flag does
// nothing. Bytes enter a 512-bit block register at one per cycle while in_stall is
// low. The word that brings the 64th byte of a block raises in_stall while the 80
// rounds of the single round unit run, one per cycle, and then while the working
// variables are folded into the chain value. On msg_end the sequencer pads the
// block itself, one byte per cycle (0x80, zeros, then the 64-bit big-endian bit
// length), followed by one compression, or by two when more than 55 bytes were
// pending, and then loads the output register. The five digest words then leave
// through that separate output register, word 0 (most significant) first with
// last_word on word 4, and the chain returns to the SHA-1 initial value. Intake
// reopens while the digest is still being read out; only a second digest waits
// until the first has been fully taken.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  msg_byte,
  input  logic        byte_valid,
  input  logic        msg_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: owns intake, padding order and the hand-off to the output.
  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .byte_valid (byte_valid),
    .msg_end    (msg_end),
    .stat       (stat),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  // Datapath: block register doubles as the rolling 16-word schedule.
  sha1_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .msg_byte    (msg_byte),
    .out_stall   (out_stall),
    .stat        (stat),
    .out_valid   (out_valid),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

`include "sha1_message_digest_macros.svh"

  // A byte that completes a block must hold off intake for the rounds.
  `SHA1_ASSERT_NEXT(a_full_block_stalls,
    in_valid && !in_stall && byte_valid && stat.fill == FILL_LAST, in_stall,
    "intake open during compression")
  // Message end always starts padding, so intake closes.
  `SHA1_ASSERT_NEXT(a_end_stalls,
    in_valid && !in_stall && msg_end, in_stall,
    "intake open after message end")
  // Taking the last digest word drains the output register.
  `SHA1_ASSERT_NEXT(a_last_drains,
    out_valid && !out_stall && last_word, !out_valid,
    "output still valid after last word")
  // Digest words leave in order.
  `SHA1_ASSERT_NEXT(a_index_steps,
    out_valid && !out_stall && !last_word, word_index == $past(word_index) + 3'd1,
    "digest word index skipped")
  // Only word 4 is flagged last.
  `SHA1_ASSERT_NOW(a_last_index,
    out_valid, last_word == (word_index == IDX_LAST),
    "last_word disagrees with index")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the byte-serial SHA-1 digest block.
`timescale 1ns / 1ps
module tb;

  // One input word: an optional message byte and an optional end mark.
  typedef struct packed {
    logic [7:0] mb;
    logic       bv;
    logic       me;
  } msg_word_t;

  // One expected digest word as it should leave the block.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_out_t;

  // Round constants and initial chain value of SHA-1.
  localparam logic [31:0] RC_0 = 32'h5A827999;
  localparam logic [31:0] RC_1 = 32'h6ED9EBA1;
  localparam logic [31:0] RC_2 = 32'h8F1BBCDC;
  localparam logic [31:0] RC_3 = 32'hCA62C1D6;
  localparam logic [31:0] IV_0 = 32'h67452301;
  localparam logic [31:0] IV_1 = 32'hEFCDAB89;
  localparam logic [31:0] IV_2 = 32'h98BADCFE;
  localparam logic [31:0] IV_3 = 32'h10325476;
  localparam logic [31:0] IV_4 = 32'hC3D2E1F0;

  localparam int WORDS_PER_PHASE = 55;
  localparam int DRAIN_CYCLES    = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  msg_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        msg_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha1_message_digest dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .msg_byte    (msg_byte),
    .byte_valid  (byte_valid),
    .msg_end     (msg_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  always #5 clk = ~clk;

  // Words waiting to be driven, and digest words the block still owes us.
  msg_word_t   stream_q[$];
  digest_out_t digest_q[$];

  int words_queued = 0;
  int words_taken  = 0;
  int mismatches   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit acc_seen = 1'b0;

  // Shadow copy of the digest state.
  logic [31:0] chain_h [5];
  logic [7:0]  blk [64];
  logic [60:0] msg_len;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void load_iv();
    chain_h[0] = IV_0;
    chain_h[1] = IV_1;
    chain_h[2] = IV_2;
    chain_h[3] = IV_3;
    chain_h[4] = IV_4;
  endfunction

  // Run the 80 rounds over blk against the chain, with the rolling schedule.
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int s;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      s = r & 15;
      if (r >= 16)
        w[s] = rol32(w[(s+13)&15] ^ w[(s+8)&15] ^ w[(s+2)&15] ^ w[s], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RC_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RC_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC_2;
      end else begin
        f = b ^ c ^ d;
        k = RC_3;
      end
      t = rol32(a, 5) + f + e + k + w[s];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Fold one accepted word into the shadow state; on message end, pad,
  // finish and queue the five digest words.
  function automatic void absorb_word(logic [7:0] mb, logic bv, logic me);
    logic [5:0]  fill;
    logic [63:0] bitlen;
    int i;
    if (bv) begin
      fill = msg_len[5:0];
      blk[fill] = mb;
      msg_len = msg_len + 61'd1;
      if (fill == 6'd63)
        compress_block();
    end
    if (me) begin
      fill = msg_len[5:0];
      bitlen = {msg_len, 3'b000};
      blk[fill] = 8'h80;
      for (i = fill + 1; i < 64; i++)
        blk[i] = 8'h00;
      // No room left for the length: close this block and start a fresh one.
      if (fill > 6'd55) begin
        compress_block();
        for (i = 0; i < 64; i++)
          blk[i] = 8'h00;
      end
      for (i = 0; i < 8; i++)
        blk[56+i] = bitlen[63-8*i -: 8];
      compress_block();
      for (i = 0; i < 5; i++)
        digest_q.push_back('{word: chain_h[i], idx: i[2:0], last: (i == 4)});
      load_iv();
      msg_len = '0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 100)
      $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Monitor: check every taken digest word against the oldest expectation,
  // then predict from any input word taken at the same edge.
  always @(posedge clk) begin : check_proc
    digest_out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest word", digest_word, 32'h0);
        end else begin
          want = digest_q.pop_front();
          if (digest_word !== want.word)
            report_mismatch("digest_word", digest_word, want.word);
          if (word_index !== want.idx)
            report_mismatch("word_index", {29'h0, word_index}, {29'h0, want.idx});
          if (last_word !== want.last)
            report_mismatch("last_word", {31'h0, last_word}, {31'h0, want.last});
        end
      end
      if (in_valid && !in_stall) begin
        absorb_word(msg_byte, byte_valid, msg_end);
        words_taken++;
      end
    end
    acc_seen <= in_valid && !in_stall;
  end

  // Driver: hold a stalled word, otherwise present the next pending word
  // unless the sender idles this cycle. Receiver stall is drawn here too.
  always @(negedge clk) begin : drive_proc
    msg_word_t nxt;
    if (!(in_valid && !acc_seen)) begin
      if (!rst && stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = stream_q.pop_front();
        in_valid   <= 1'b1;
        msg_byte   <= nxt.mb;
        byte_valid <= nxt.bv;
        msg_end    <= nxt.me;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic queue_word(logic [7:0] mb, logic bv, logic me);
    stream_q.push_back('{mb: mb, bv: bv, me: me});
    words_queued++;
  endtask

  // Queue one well-formed message of random bytes with a few no-op words
  // mixed in; close it either on its last byte or with a bare end word.
  task automatic queue_message(int len);
    bit end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(0, 15) == 0)
        queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      queue_word(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (j == len - 1));
    end
    if (!end_on_byte)
      queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Mostly short messages, some near the padding and block boundaries.
  function automatic int pick_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 6);
      4, 5:       return $urandom_range(7, 30);
      6, 7:       return $urandom_range(53, 58);
      default:    return $urandom_range(61, 70);
    endcase
  endfunction

  // Hold off until everything queued is taken and every digest has come.
  task automatic wait_idle();
    while (words_taken != words_queued || digest_q.size() != 0)
      @(negedge clk);
  endtask

  // One phase: set idling and receiver stall, queue a boundary-length message and
  // then random ones, and drain before moving on.
  task automatic run_phase(int idle, int stall, int first_len);
    int start;
    @(posedge clk);
    send_idle_pct = idle;
    stall_pct = stall;
    start = words_queued;
    queue_message(first_len);
    while (words_queued - start < WORDS_PER_PHASE)
      queue_message(pick_len());
    wait_idle();
  endtask

  initial begin
    load_iv();
    msg_len = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening, no idling.
    @(posedge clk);
    queue_word(8'h5A, 1'b0, 1'b0);   // no-op word right after reset
    queue_word(8'hFF, 1'b0, 1'b1);   // empty message, ignored byte all ones
    queue_word(8'h61, 1'b1, 1'b0);   // "abc", end on the last byte
    queue_word(8'h62, 1'b1, 1'b0);
    queue_word(8'h63, 1'b1, 1'b1);
    queue_word(8'h00, 1'b1, 1'b0);   // all-zero and all-one bytes
    queue_word(8'hFF, 1'b1, 1'b0);
    queue_word(8'hA5, 1'b0, 1'b0);   // no-op inside a message
    queue_word(8'h00, 1'b0, 1'b1);   // bare end word
    queue_word(8'h80, 1'b1, 1'b1);   // single byte that looks like the pad mark
    wait_idle();

    // Boundary lengths: last fit, first spill, one short of full, exactly full.
    run_phase(0, 0, 55);
    run_phase(65, 0, 56);
    run_phase(0, 65, 63);
    run_phase(35, 35, 64);

    // Give the block time to show any stray output.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** sha1_message_digest: PASSED **");
    else
      $display("** sha1_message_digest: FAILED **");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("** sha1_message_digest: FAILED **");
    $finish;
  end

endmodule
